FILE: design/set_assoc_lru_cache_sim_top_macros.svh
// Assertion macros for the set-associative cache model.
`ifndef SET_ASSOC_LRU_CACHE_SIM_TOP_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_SIM_TOP_MACROS_SVH

// cons holds in the cycle of ante
`define SALC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// cons holds in the cycle after ante
`define SALC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/salc_pkg.sv
// Types, constants and helpers shared by the cache model files.
package salc_pkg;

	localparam int CNT_W      = 32;
	localparam int STAMP_W    = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;
	localparam int SET_CFG_W  = 3;
	localparam int WAY_CFG_W  = 4;
	localparam int BLK_CFG_W  = 4;
	localparam int SHAMT_W    = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS_USED  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd2;

	localparam logic [SET_CFG_W-1:0] SET_BITS_RST   = 3'd4;
	localparam logic [WAY_CFG_W-1:0] WAYS_USED_RST  = 4'd1;
	localparam logic [BLK_CFG_W-1:0] BLOCK_BITS_RST = 4'd4;

	localparam logic [STAMP_W-1:0] CLOCK_RST = 32'd1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_WRITE
	} salc_state_t;

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] v,
		input logic [1:0] inc);
		logic [CNT_W+1:0] s;
		s = {2'b00, v} + {{CNT_W{1'b0}}, inc};
		sat_add = (s[CNT_W+1:CNT_W] != 2'b00) ? {CNT_W{1'b1}} : s[CNT_W-1:0];
	endfunction

endpackage

FILE: design/salc_if.sv
// Access and result channel interfaces of the cache model.
interface salc_req_if #(parameter int ADDR_WIDTH = 48);
	logic                  valid;
	logic                  ready;
	logic [ADDR_WIDTH-1:0] address;
	logic                  mode;

	modport source (output valid, output address, output mode, input ready);
	modport sink (input valid, input address, input mode, output ready);
endinterface

interface salc_rsp_if;
	import salc_pkg::*;

	logic             valid;
	logic             ready;
	logic             first_hit;
	logic             evicted;
	logic             second_hit;
	logic [CNT_W-1:0] hit_total;
	logic [CNT_W-1:0] miss_total;
	logic [CNT_W-1:0] eviction_total;

	modport source (output valid, output first_hit, output evicted, output second_hit,
		output hit_total, output miss_total, output eviction_total, input ready);
	modport sink (input valid, input first_hit, input evicted, input second_hit,
		input hit_total, input miss_total, input eviction_total, output ready);
endinterface

FILE: design/salc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module salc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wa,
	input  logic [WIDTH-1:0]                       wd,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] ra,
	output logic [WIDTH-1:0]                       rd
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd <= mem[ra];
	end
endmodule

FILE: design/set_assoc_lru_cache_sim_top.sv
// Set-associative cache model with LRU replacement: one access in, one result word out.
// Each access is split into tag and set by the set_bits and block_bits registers, and the
// ways of its set are read one per cycle through a single read port of the tag and line
// state tables, while one compare unit tracks the first hit, first invalid way and oldest
// way. An access goes through accept, a scan of the ways in use and a write-back step that
// waits for a free result slot; the result word is registered, so the next access is taken
// while the previous result waits. After reset the line state table is cleared one line a
// cycle, all 2^MAX_SET_BITS * MAX_WAYS lines (512 by default), during which no access is
// taken; register writes are taken at any time.
`include "set_assoc_lru_cache_sim_top_macros.svh"

module set_assoc_lru_cache_sim_top #(
	parameter int MAX_SET_BITS = 6,
	parameter int MAX_WAYS     = 8,
	parameter int ADDR_WIDTH   = 48
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [salc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [salc_pkg::CFG_DATA_W-1:0] cfg_data,
	salc_req_if.sink                     req,
	salc_rsp_if.source                   rsp
);
	import salc_pkg::*;

	localparam int LINES   = (1 << MAX_SET_BITS) * MAX_WAYS;
	localparam int LINE_AW = (LINES > 1) ? $clog2(LINES) : 1;
	localparam int SET_W   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int WCNT_W  = $clog2(MAX_WAYS + 1);
	localparam int META_W  = STAMP_W + 1;

	salc_state_t state_q, state_d;

	logic [SET_CFG_W-1:0] cfg_set_q;
	logic [WAY_CFG_W-1:0] cfg_ways_q;
	logic [BLK_CFG_W-1:0] cfg_block_q;

	logic [LINE_AW-1:0]    clr_q;
	logic [ADDR_WIDTH-1:0] tag_q;
	logic [SET_W-1:0]      set_q;
	logic [WCNT_W-1:0]     ways_q;
	logic                  mode_q;
	logic [WCNT_W-1:0]     cnt_q;

	logic               hit_fnd_q, inv_fnd_q;
	logic [WAY_W-1:0]   hit_way_q, inv_way_q, best_way_q;
	logic [STAMP_W-1:0] best_age_q;

	logic [STAMP_W-1:0] acc_clock_q;
	logic [CNT_W-1:0]   hits_q, misses_q, evicts_q;

	logic               rsp_vld_q;
	logic               first_hit_q, evicted_q, second_hit_q;
	logic [CNT_W-1:0]   hit_total_q, miss_total_q, evict_total_q;

	logic                  req_acc;
	logic                  out_free;
	logic                  out_load;
	logic                  meta_we, tag_we;
	logic [LINE_AW-1:0]    meta_wa, line_wa, rd_addr;
	logic [META_W-1:0]     meta_wd, meta_rd;
	logic [ADDR_WIDTH-1:0] tag_rd;

	logic [SET_CFG_W-1:0]  sb_eff;
	logic [SHAMT_W-1:0]    shamt;
	logic [ADDR_WIDTH-1:0] blk_shifted;
	logic [SET_W-1:0]      set_mask;
	logic [WCNT_W-1:0]     ways_eff;

	logic               evaluating;
	logic [WAY_W-1:0]   ev_way, rd_way, tgt_way;
	logic               rd_valid;
	logic [STAMP_W-1:0] rd_age;
	logic               do_evict;

	// decode access geometry
	always_comb begin
		sb_eff      = (32'(cfg_set_q) > MAX_SET_BITS) ? SET_CFG_W'(MAX_SET_BITS) : cfg_set_q;
		shamt       = SHAMT_W'(sb_eff) + SHAMT_W'(cfg_block_q);
		blk_shifted = req.address >> cfg_block_q;
		set_mask    = ~({SET_W{1'b1}} << sb_eff);
		if (cfg_ways_q == '0) begin
			ways_eff = WCNT_W'(1);
		end else if (32'(cfg_ways_q) > MAX_WAYS) begin
			ways_eff = WCNT_W'(MAX_WAYS);
		end else begin
			ways_eff = WCNT_W'(cfg_ways_q);
		end
	end

	assign req_acc  = req.valid && req.ready;
	assign out_free = !rsp_vld_q || rsp.ready;

	assign evaluating = (state_q == ST_SCAN) && (cnt_q != '0);
	assign ev_way     = WAY_W'(cnt_q - WCNT_W'(1));
	assign rd_way     = WAY_W'(cnt_q);
	assign rd_valid   = meta_rd[META_W-1];
	assign rd_age     = acc_clock_q - meta_rd[STAMP_W-1:0];
	assign do_evict   = !hit_fnd_q && !inv_fnd_q;
	assign tgt_way    = hit_fnd_q ? hit_way_q : (inv_fnd_q ? inv_way_q : best_way_q);
	assign line_wa    = LINE_AW'(set_q) * LINE_AW'(MAX_WAYS) + LINE_AW'(tgt_way);
	assign rd_addr    = LINE_AW'(set_q) * LINE_AW'(MAX_WAYS) + LINE_AW'(rd_way);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == LINE_AW'(LINES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req.valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (cnt_q == ways_q) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready = 1'b0;
		meta_we   = 1'b0;
		tag_we    = 1'b0;
		out_load  = 1'b0;
		meta_wa   = line_wa;
		meta_wd   = {1'b1, acc_clock_q};
		unique case (state_q)
			ST_CLEAR: begin
				meta_we = 1'b1;
				meta_wa = clr_q;
				meta_wd = '0;
			end
			ST_IDLE: begin
				req.ready = 1'b1;
			end
			ST_SCAN: begin
			end
			ST_WRITE: begin
				meta_we  = out_free;
				tag_we   = out_free && !hit_fnd_q;
				out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	salc_ram #(.WIDTH(META_W), .DEPTH(LINES)) u_meta_ram (
		.clk (clk),
		.we  (meta_we),
		.wa  (meta_wa),
		.wd  (meta_wd),
		.ra  (rd_addr),
		.rd  (meta_rd)
	);

	salc_ram #(.WIDTH(ADDR_WIDTH), .DEPTH(LINES)) u_tag_ram (
		.clk (clk),
		.we  (tag_we),
		.wa  (line_wa),
		.wd  (tag_q),
		.ra  (rd_addr),
		.rd  (tag_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			cfg_set_q   <= SET_BITS_RST;
			cfg_ways_q  <= WAYS_USED_RST;
			cfg_block_q <= BLOCK_BITS_RST;
			cnt_q       <= '0;
			hit_fnd_q   <= 1'b0;
			inv_fnd_q   <= 1'b0;
			acc_clock_q <= CLOCK_RST;
			hits_q      <= '0;
			misses_q    <= '0;
			evicts_q    <= '0;
			rsp_vld_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + LINE_AW'(1);
			end
			if (cfg_wr_en) begin
				unique case (cfg_index)
					CFG_SET_BITS:   cfg_set_q   <= cfg_data[SET_CFG_W-1:0];
					CFG_WAYS_USED:  cfg_ways_q  <= cfg_data[WAY_CFG_W-1:0];
					CFG_BLOCK_BITS: cfg_block_q <= cfg_data[BLK_CFG_W-1:0];
					default: begin
					end
				endcase
			end
			if (req_acc) begin
				cnt_q     <= '0;
				hit_fnd_q <= 1'b0;
				inv_fnd_q <= 1'b0;
			end else if (state_q == ST_SCAN && cnt_q != ways_q) begin
				cnt_q <= cnt_q + WCNT_W'(1);
			end
			if (evaluating) begin
				if (!hit_fnd_q && rd_valid && tag_rd == tag_q) begin
					hit_fnd_q <= 1'b1;
				end
				if (!inv_fnd_q && !rd_valid) begin
					inv_fnd_q <= 1'b1;
				end
			end
			if (out_load) begin
				acc_clock_q <= acc_clock_q + STAMP_W'(1);
				hits_q      <= sat_add(hits_q, {1'b0, hit_fnd_q} + {1'b0, mode_q});
				misses_q    <= sat_add(misses_q, {1'b0, !hit_fnd_q});
				evicts_q    <= sat_add(evicts_q, {1'b0, do_evict});
				rsp_vld_q   <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_acc) begin
			tag_q  <= req.address >> shamt;
			set_q  <= SET_W'(blk_shifted) & set_mask;
			ways_q <= ways_eff;
			mode_q <= req.mode;
		end
		if (evaluating) begin
			if (!hit_fnd_q && rd_valid && tag_rd == tag_q) begin
				hit_way_q <= ev_way;
			end
			if (!inv_fnd_q && !rd_valid) begin
				inv_way_q <= ev_way;
			end
			if (cnt_q == WCNT_W'(1) || rd_age > best_age_q) begin
				best_age_q <= rd_age;
				best_way_q <= ev_way;
			end
		end
		if (out_load) begin
			first_hit_q   <= hit_fnd_q;
			evicted_q     <= do_evict;
			second_hit_q  <= mode_q;
			hit_total_q   <= sat_add(hits_q, {1'b0, hit_fnd_q} + {1'b0, mode_q});
			miss_total_q  <= sat_add(misses_q, {1'b0, !hit_fnd_q});
			evict_total_q <= sat_add(evicts_q, {1'b0, do_evict});
		end
	end

	assign rsp.valid          = rsp_vld_q;
	assign rsp.first_hit      = first_hit_q;
	assign rsp.evicted        = evicted_q;
	assign rsp.second_hit     = second_hit_q;
	assign rsp.hit_total      = hit_total_q;
	assign rsp.miss_total     = miss_total_q;
	assign rsp.eviction_total = evict_total_q;

	`SALC_ASSERT_NEXT(a_acc_scan, clk, arst_n, req_acc, state_q == ST_SCAN, "accepted access did not start a scan")
	`SALC_ASSERT_SAME(a_scan_bound, clk, arst_n, state_q == ST_SCAN, cnt_q <= ways_q, "scan ran past the ways in use")
	`SALC_ASSERT_SAME(a_meta_wr, clk, arst_n, meta_we, state_q == ST_WRITE || state_q == ST_CLEAR, "line state written outside write-back or clear")
	`SALC_ASSERT_SAME(a_hit_evict, clk, arst_n, rsp_vld_q, !(first_hit_q && evicted_q), "word reports both hit and eviction")
	`SALC_ASSERT_NEXT(a_load_valid, clk, arst_n, out_load, rsp_vld_q, "loaded word not presented")
endmodule
